// File: hw/rtl/tmse_pkg.sv
package tmse_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PC_W      = 5;

  localparam logic [TIME_W-1:0] TIME_STEP_RST = TIME_W'(65);
  localparam logic [TIME_W-1:0] END_TIME_RST  = TIME_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FX_ONE        = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FX_MAX        = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] FX_MIN        = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [PC_W-1:0] PC_START = PC_W'(0);
  localparam logic [PC_W-1:0] PC_END   = PC_W'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP     = 3'd0,
    CFG_END_TIME      = 3'd1,
    CFG_STIFFNESS_ONE = 3'd2,
    CFG_STIFFNESS_TWO = 3'd3,
    CFG_INV_MASS_ONE  = 3'd4,
    CFG_INV_MASS_TWO  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OPC_LOAD = 1'b0,
    OPC_STEP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    UOP_NOP = 2'd0,
    UOP_ADD = 2'd1,
    UOP_SUB = 2'd2,
    UOP_MUL = 2'd3
  } uop_e;

  typedef enum logic [3:0] {
    SRC_U1  = 4'd0,
    SRC_U2  = 4'd1,
    SRC_V1  = 4'd2,
    SRC_V2  = 4'd3,
    SRC_R0  = 4'd4,
    SRC_R1  = 4'd5,
    SRC_R2  = 4'd6,
    SRC_F1  = 4'd7,
    SRC_F2  = 4'd8,
    SRC_K1  = 4'd9,
    SRC_K2  = 4'd10,
    SRC_IM1 = 4'd11,
    SRC_IM2 = 4'd12,
    SRC_DT  = 4'd13
  } src_e;

  typedef struct packed {
    uop_e uop;
    src_e src_a;
    src_e src_b;
    src_e dst;
    logic branch;
    logic last;
  } ucode_t;

  function automatic ucode_t uword(uop_e uop, src_e a, src_e b, src_e d);
    ucode_t w;
    w.uop    = uop;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.branch = 1'b0;
    w.last   = 1'b0;
    return w;
  endfunction

  // step program, all terms from the old state; refused steps jump to the end word
  function automatic ucode_t prog(logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0: begin
        w = uword(UOP_NOP, SRC_U1, SRC_U1, SRC_U1);
        w.branch = 1'b1;
      end
      5'd1:  w = uword(UOP_SUB, SRC_U2,  SRC_U1, SRC_R0);
      5'd2:  w = uword(UOP_MUL, SRC_K2,  SRC_R0, SRC_R0);
      5'd3:  w = uword(UOP_MUL, SRC_K1,  SRC_U1, SRC_R1);
      5'd4:  w = uword(UOP_SUB, SRC_R0,  SRC_R1, SRC_R1);
      5'd5:  w = uword(UOP_ADD, SRC_F1,  SRC_R1, SRC_R1);
      5'd6:  w = uword(UOP_SUB, SRC_F2,  SRC_R0, SRC_R0);
      5'd7:  w = uword(UOP_MUL, SRC_IM1, SRC_R1, SRC_R1);
      5'd8:  w = uword(UOP_MUL, SRC_IM2, SRC_R0, SRC_R0);
      5'd9:  w = uword(UOP_MUL, SRC_DT,  SRC_R1, SRC_R1);
      5'd10: w = uword(UOP_MUL, SRC_DT,  SRC_R0, SRC_R0);
      5'd11: w = uword(UOP_MUL, SRC_DT,  SRC_V1, SRC_R2);
      5'd12: w = uword(UOP_ADD, SRC_V1,  SRC_R1, SRC_V1);
      5'd13: w = uword(UOP_MUL, SRC_DT,  SRC_V2, SRC_R1);
      5'd14: w = uword(UOP_ADD, SRC_V2,  SRC_R0, SRC_V2);
      5'd15: w = uword(UOP_ADD, SRC_U1,  SRC_R2, SRC_U1);
      5'd16: w = uword(UOP_ADD, SRC_U2,  SRC_R1, SRC_U2);
      default: begin
        w = uword(UOP_NOP, SRC_U1, SRC_U1, SRC_U1);
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/tmse_if.sv
interface tmse_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] init_pos_one;
  logic [31:0] init_pos_two;
  logic [31:0] init_vel_one;
  logic [31:0] init_vel_two;
  logic [31:0] force_one;
  logic [31:0] force_two;

  modport source (
    output valid, opcode, init_pos_one, init_pos_two, init_vel_one, init_vel_two,
           force_one, force_two,
    input  ready
  );
  modport sink (
    input  valid, opcode, init_pos_one, init_pos_two, init_vel_one, init_vel_two,
           force_one, force_two,
    output ready
  );
endinterface

interface tmse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_one;
  logic [31:0] pos_two;
  logic [31:0] vel_one;
  logic [31:0] vel_two;
  logic        done_res;
  logic        saturated;

  modport source (
    output valid, pos_one, pos_two, vel_one, vel_two, done_res, saturated,
    input  ready
  );
  modport sink (
    input  valid, pos_one, pos_two, vel_one, vel_two, done_res, saturated,
    output ready
  );
endinterface

interface tmse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hw/rtl/two_mass_spring_euler_step.sv
// two-mass spring oscillator, one forward euler step per item, signed q16.16
// step_in_i: items of opcode load (sets u1, u2, v1, v2, time = dt) or step
//   (advances the state by dt while the running time is at most end_time)
// result_o: one item per input item, the state after it plus done and
//   saturation flags
// cfg_i: register writes, always ready; write only while the block is idle
// timing: an item is taken only while the sequencer is idle. a step runs an
//   18-word microprogram on one shared 32x32 multiplier and adder, and no new
//   item is taken until the current one has left the end word; a load goes
//   straight to the end word and a refused step branches there from word 0.
// a finished result sits in the output register; the next item is accepted
//   meanwhile, and the sequencer waits in its end word if the receiver
//   still holds the previous result
// reset: state, running time and flags clear, registers take their
//   defaults (dt 65, end time 1.0, stiffness and reciprocal masses 1.0)
module two_mass_spring_euler_step (
  input  logic clk_i,
  input  logic rst_ni,
  tmse_in_if.sink    step_in_i,
  tmse_out_if.source result_o,
  tmse_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [tmse_pkg::PC_W-1:0] pc_q, pc_d;

  logic [tmse_pkg::TIME_W-1:0] dt_q, end_q;
  logic [31:0] k1_q, k2_q, im1_q, im2_q;

  logic [31:0] u1_q, u2_q, v1_q, v2_q;
  logic [31:0] r0_q, r1_q, r2_q;
  logic [31:0] f1_q, f2_q;
  logic [31:0] elapsed_q;
  logic        refused_q;
  logic        sat_q;

  logic        out_valid_q;
  logic [31:0] out_u1_q, out_u2_q, out_v1_q, out_v2_q;
  logic        out_done_q, out_sat_q;

  tmse_pkg::ucode_t cw;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod, prod_sh;
  logic signed [32:0] sum;
  logic [31:0] alu_res;
  logic        alu_clip;
  logic        in_acc, out_free, finish, refuse_now;
  logic [32:0] time_sum;
  logic [31:0] time_next;

  assign in_acc   = step_in_i.valid && step_in_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign step_in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign cw = tmse_pkg::prog(pc_q);
  assign finish = (state_q == ST_RUN) && cw.last && out_free;

  assign refuse_now = elapsed_q > {1'b0, end_q};
  assign time_sum   = {1'b0, elapsed_q} + {2'b00, dt_q};
  assign time_next  = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];

  function automatic logic [31:0] pick(tmse_pkg::src_e s, logic [31:0] u1, logic [31:0] u2,
                                       logic [31:0] v1, logic [31:0] v2, logic [31:0] r0,
                                       logic [31:0] r1, logic [31:0] r2, logic [31:0] f1,
                                       logic [31:0] f2, logic [31:0] k1, logic [31:0] k2,
                                       logic [31:0] im1, logic [31:0] im2,
                                       logic [30:0] dt);
    logic [31:0] v;
    case (s)
      tmse_pkg::SRC_U1:  v = u1;
      tmse_pkg::SRC_U2:  v = u2;
      tmse_pkg::SRC_V1:  v = v1;
      tmse_pkg::SRC_V2:  v = v2;
      tmse_pkg::SRC_R0:  v = r0;
      tmse_pkg::SRC_R1:  v = r1;
      tmse_pkg::SRC_R2:  v = r2;
      tmse_pkg::SRC_F1:  v = f1;
      tmse_pkg::SRC_F2:  v = f2;
      tmse_pkg::SRC_K1:  v = k1;
      tmse_pkg::SRC_K2:  v = k2;
      tmse_pkg::SRC_IM1: v = im1;
      tmse_pkg::SRC_IM2: v = im2;
      tmse_pkg::SRC_DT:  v = {1'b0, dt};
      default:           v = '0;
    endcase
    return v;
  endfunction

  assign op_a = pick(cw.src_a, u1_q, u2_q, v1_q, v2_q, r0_q, r1_q, r2_q, f1_q, f2_q,
                     k1_q, k2_q, im1_q, im2_q, dt_q);
  assign op_b = pick(cw.src_b, u1_q, u2_q, v1_q, v2_q, r0_q, r1_q, r2_q, f1_q, f2_q,
                     k1_q, k2_q, im1_q, im2_q, dt_q);

  // product shifted with floor rounding, sums kept one bit wider for the clip
  assign prod    = op_a * op_b;
  assign prod_sh = prod >>> tmse_pkg::FRAC_BITS;

  always_comb begin
    sum      = '0;
    alu_res  = '0;
    alu_clip = 1'b0;
    case (cw.uop)
      tmse_pkg::UOP_ADD, tmse_pkg::UOP_SUB: begin
        if (cw.uop == tmse_pkg::UOP_ADD) begin
          sum = {op_a[31], op_a} + {op_b[31], op_b};
        end else begin
          sum = {op_a[31], op_a} - {op_b[31], op_b};
        end
        alu_clip = sum[32] != sum[31];
        alu_res  = alu_clip ? (sum[32] ? tmse_pkg::FX_MIN : tmse_pkg::FX_MAX) : sum[31:0];
      end
      tmse_pkg::UOP_MUL: begin
        alu_clip = prod_sh[63:31] != {33{prod_sh[63]}};
        alu_res  = alu_clip ? (prod_sh[63] ? tmse_pkg::FX_MIN : tmse_pkg::FX_MAX)
                            : prod_sh[31:0];
      end
      default: begin
        alu_res  = '0;
        alu_clip = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          pc_d = (step_in_i.opcode == tmse_pkg::OPC_LOAD) ? tmse_pkg::PC_END
                                                          : tmse_pkg::PC_START;
        end
      end
      ST_RUN: begin
        if (cw.last) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (cw.branch && refused_q) begin
          pc_d = tmse_pkg::PC_END;
        end else begin
          pc_d = pc_q + tmse_pkg::PC_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        pc_d    = tmse_pkg::PC_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= tmse_pkg::PC_START;
      out_valid_q <= 1'b0;
      dt_q        <= tmse_pkg::TIME_STEP_RST;
      end_q       <= tmse_pkg::END_TIME_RST;
      k1_q        <= tmse_pkg::FX_ONE;
      k2_q        <= tmse_pkg::FX_ONE;
      im1_q       <= tmse_pkg::FX_ONE;
      im2_q       <= tmse_pkg::FX_ONE;
      u1_q        <= '0;
      u2_q        <= '0;
      v1_q        <= '0;
      v2_q        <= '0;
      elapsed_q   <= '0;
      refused_q   <= 1'b0;
      sat_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;

      if (cfg_i.valid) begin
        case (cfg_i.index)
          tmse_pkg::CFG_TIME_STEP:     dt_q  <= cfg_i.data[tmse_pkg::TIME_W-1:0];
          tmse_pkg::CFG_END_TIME:      end_q <= cfg_i.data[tmse_pkg::TIME_W-1:0];
          tmse_pkg::CFG_STIFFNESS_ONE: k1_q  <= cfg_i.data;
          tmse_pkg::CFG_STIFFNESS_TWO: k2_q  <= cfg_i.data;
          tmse_pkg::CFG_INV_MASS_ONE:  im1_q <= cfg_i.data;
          tmse_pkg::CFG_INV_MASS_TWO:  im2_q <= cfg_i.data;
          default: ;
        endcase
      end

      if (in_acc) begin
        sat_q <= 1'b0;
        if (step_in_i.opcode == tmse_pkg::OPC_LOAD) begin
          u1_q      <= step_in_i.init_pos_one;
          u2_q      <= step_in_i.init_pos_two;
          v1_q      <= step_in_i.init_vel_one;
          v2_q      <= step_in_i.init_vel_two;
          elapsed_q <= {1'b0, dt_q};
          refused_q <= 1'b0;
        end else begin
          refused_q <= refuse_now;
          if (!refuse_now) begin
            elapsed_q <= time_next;
          end
        end
      end else if (state_q == ST_RUN && cw.uop != tmse_pkg::UOP_NOP) begin
        sat_q <= sat_q | alu_clip;
        case (cw.dst)
          tmse_pkg::SRC_U1: u1_q <= alu_res;
          tmse_pkg::SRC_U2: u2_q <= alu_res;
          tmse_pkg::SRC_V1: v1_q <= alu_res;
          tmse_pkg::SRC_V2: v2_q <= alu_res;
          default: ;
        endcase
      end

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scratch, forces and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f1_q <= step_in_i.force_one;
      f2_q <= step_in_i.force_two;
    end
    if (state_q == ST_RUN && cw.uop != tmse_pkg::UOP_NOP) begin
      case (cw.dst)
        tmse_pkg::SRC_R0: r0_q <= alu_res;
        tmse_pkg::SRC_R1: r1_q <= alu_res;
        tmse_pkg::SRC_R2: r2_q <= alu_res;
        default: ;
      endcase
    end
    if (finish) begin
      out_u1_q   <= u1_q;
      out_u2_q   <= u2_q;
      out_v1_q   <= v1_q;
      out_v2_q   <= v2_q;
      out_done_q <= refused_q;
      out_sat_q  <= sat_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.pos_one   = out_u1_q;
  assign result_o.pos_two   = out_u2_q;
  assign result_o.vel_one   = out_v1_q;
  assign result_o.vel_two   = out_v2_q;
  assign result_o.done_res  = out_done_q;
  assign result_o.saturated = out_sat_q;

  a_run_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> pc_q <= tmse_pkg::PC_END)
    else $error("program counter beyond end word");

  a_refused_jumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && pc_q == tmse_pkg::PC_START && refused_q)
      |=> pc_q == tmse_pkg::PC_END)
    else $error("refused step did not jump to end word");

  a_done_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.done_res) |-> !result_o.saturated)
    else $error("refused item reports saturation");

  a_time_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && step_in_i.opcode == tmse_pkg::OPC_STEP) |=> elapsed_q >= $past(elapsed_q))
    else $error("running time went backwards on a step");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RUN && pc_q == tmse_pkg::PC_END))
    else $error("result raised outside the end word");

endmodule

// File: tb/two_mass_spring_euler_step_test.sv
`timescale 1ns / 100ps

module two_mass_spring_euler_step_test;

  localparam int     STALL_LIMIT = 3000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     PHASES      = 12;
  localparam int     PHASE_ITEMS = 88;
  localparam longint WORD_HI     = longint'($signed(tmse_pkg::FX_MAX));
  localparam longint WORD_LO     = longint'($signed(tmse_pkg::FX_MIN));

  localparam logic [tmse_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [tmse_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    tmse_pkg::opcode_e  opcode;
    logic signed [31:0] pos_one;
    logic signed [31:0] pos_two;
    logic signed [31:0] vel_one;
    logic signed [31:0] vel_two;
    logic signed [31:0] force_one;
    logic signed [31:0] force_two;
  } spring_item_t;

  typedef struct {
    logic [31:0] pos_one;
    logic [31:0] pos_two;
    logic [31:0] vel_one;
    logic [31:0] vel_two;
    logic        done_res;
    logic        saturated;
  } spring_state_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b1;

  tmse_in_if  step_if ();
  tmse_out_if res_if ();
  tmse_cfg_if cfg_if ();

  two_mass_spring_euler_step dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .step_in_i (step_if),
    .result_o  (res_if),
    .cfg_i     (cfg_if)
  );

  always #10 clk = ~clk;

  // predictor state and register copies
  logic [tmse_pkg::TIME_W-1:0] dt_val   = tmse_pkg::TIME_STEP_RST;
  logic [tmse_pkg::TIME_W-1:0] end_val  = tmse_pkg::END_TIME_RST;
  longint            k_ground = longint'(tmse_pkg::FX_ONE);
  longint            k_couple = longint'(tmse_pkg::FX_ONE);
  longint            rmass_a  = longint'(tmse_pkg::FX_ONE);
  longint            rmass_b  = longint'(tmse_pkg::FX_ONE);
  longint            pos_a    = 0;
  longint            pos_b    = 0;
  longint            vel_a    = 0;
  longint            vel_b    = 0;
  logic [31:0]       run_time = '0;
  bit                clip_seen;

  spring_item_t  queued_items[$];
  spring_state_t predicted_states[$];
  spring_item_t  offered;
  spring_state_t want;

  int       error_count  = 0;
  int       idle_cycles  = 0;
  int       burst_left   = 0;
  int       gap_left     = 0;
  int       seen_results = 0;
  int       holds_done   = 0;
  int       hold_left    = 0;
  int       mode_left    = 0;
  int       stall_mode   = 0;
  logic [7:0] wave_cnt   = '0;
  bit       rdy;

  function automatic longint clamp_word(longint v);
    if (v > WORD_HI) begin
      clip_seen = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      clip_seen = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  function automatic longint fixed_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fixed_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  // exact product, floor shift, then clip
  function automatic longint fixed_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp_word(p >>> tmse_pkg::FRAC_BITS);
  endfunction

  function automatic spring_state_t euler_advance(spring_item_t it);
    spring_state_t r;
    longint dt, gap, couple, ground, sum_a, sum_b, acc_a, acc_b;
    longint nu_a, nu_b, nv_a, nv_b;
    logic [32:0] t_next;
    clip_seen  = 1'b0;
    r.done_res = 1'b0;
    if (it.opcode == tmse_pkg::OPC_LOAD) begin
      pos_a    = longint'(it.pos_one);
      pos_b    = longint'(it.pos_two);
      vel_a    = longint'(it.vel_one);
      vel_b    = longint'(it.vel_two);
      run_time = {1'b0, dt_val};
    end else if (run_time <= {1'b0, end_val}) begin
      dt     = longint'(dt_val);
      gap    = fixed_sub(pos_b, pos_a);
      couple = fixed_mul(k_couple, gap);
      ground = fixed_mul(k_ground, pos_a);
      sum_a  = fixed_add(longint'(it.force_one), fixed_sub(couple, ground));
      sum_b  = fixed_sub(longint'(it.force_two), couple);
      acc_a  = fixed_mul(rmass_a, sum_a);
      acc_b  = fixed_mul(rmass_b, sum_b);
      nu_a   = fixed_add(pos_a, fixed_mul(dt, vel_a));
      nu_b   = fixed_add(pos_b, fixed_mul(dt, vel_b));
      nv_a   = fixed_add(vel_a, fixed_mul(dt, acc_a));
      nv_b   = fixed_add(vel_b, fixed_mul(dt, acc_b));
      pos_a  = nu_a;
      pos_b  = nu_b;
      vel_a  = nv_a;
      vel_b  = nv_b;
      t_next = {1'b0, run_time} + 33'(dt_val);
      run_time = t_next[32] ? '1 : t_next[31:0];
    end else begin
      r.done_res = 1'b1;
    end
    r.pos_one   = pos_a[31:0];
    r.pos_two   = pos_b[31:0];
    r.vel_one   = vel_a[31:0];
    r.vel_two   = vel_b[31:0];
    r.saturated = clip_seen;
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {{13{r[18]}}, r[18:0]};
      4, 5, 6:    return r;
      7:          return tmse_pkg::FX_MAX;
      8:          return tmse_pkg::FX_MIN;
      default:    return r[0] ? tmse_pkg::FX_ONE : 32'h0;
    endcase
  endfunction

  function automatic spring_item_t random_item(tmse_pkg::opcode_e op);
    spring_item_t it;
    it.opcode  = op;
    it.pos_one = random_word();
    it.pos_two = random_word();
    it.vel_one = random_word();
    it.vel_two = random_word();
    if ($urandom_range(0, 9) < 7) begin
      it.force_one = '0;
      it.force_two = '0;
    end else begin
      it.force_one = random_word();
      it.force_two = random_word();
    end
    return it;
  endfunction

  task automatic push_item(tmse_pkg::opcode_e op, logic [31:0] u1, logic [31:0] u2,
                           logic [31:0] v1, logic [31:0] v2,
                           logic [31:0] f1, logic [31:0] f2);
    spring_item_t it;
    it.opcode    = op;
    it.pos_one   = u1;
    it.pos_two   = u2;
    it.vel_one   = v1;
    it.vel_two   = v2;
    it.force_one = f1;
    it.force_two = f2;
    queued_items.push_back(it);
  endtask

  task automatic write_register(logic [tmse_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      tmse_pkg::CFG_TIME_STEP:     dt_val   = value[tmse_pkg::TIME_W-1:0];
      tmse_pkg::CFG_END_TIME:      end_val  = value[tmse_pkg::TIME_W-1:0];
      tmse_pkg::CFG_STIFFNESS_ONE: k_ground = longint'($signed(value));
      tmse_pkg::CFG_STIFFNESS_TWO: k_couple = longint'($signed(value));
      tmse_pkg::CFG_INV_MASS_ONE:  rmass_a  = longint'($signed(value));
      tmse_pkg::CFG_INV_MASS_TWO:  rmass_b  = longint'($signed(value));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] dt, logic [31:0] stop, logic [31:0] k1,
                           logic [31:0] k2, logic [31:0] im1, logic [31:0] im2);
    write_register(tmse_pkg::CFG_TIME_STEP, dt);
    write_register(tmse_pkg::CFG_END_TIME, stop);
    write_register(tmse_pkg::CFG_STIFFNESS_ONE, k1);
    write_register(tmse_pkg::CFG_STIFFNESS_TWO, k2);
    write_register(tmse_pkg::CFG_INV_MASS_ONE, im1);
    write_register(tmse_pkg::CFG_INV_MASS_TWO, im2);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (queued_items.size() != 0 || step_if.valid || predicted_states.size() != 0)
      @(negedge clk);
  endtask

  task automatic random_settings();
    logic [31:0] step_w, end_w;
    longint      span;
    case ($urandom_range(0, 5))
      0:       step_w = $urandom_range(1, 4096);
      1, 2:    step_w = $urandom_range(1024, 131072);
      3:       step_w = $urandom;
      4:       step_w = '0;
      default: step_w = tmse_pkg::FX_MAX;
    endcase
    span = longint'(step_w[tmse_pkg::TIME_W-1:0]) * $urandom_range(0, 20);
    case ($urandom_range(0, 7))
      0:       end_w = $urandom;
      1:       end_w = '0;
      2:       end_w = tmse_pkg::FX_MAX;
      default: end_w = (span > WORD_HI) ? tmse_pkg::FX_MAX : 32'(span);
    endcase
    end_w[31] = 1'($urandom_range(0, 1));
    write_all(step_w, end_w, random_word(), random_word(), random_word(), random_word());
  endtask

  task automatic queue_phase(int count);
    spring_item_t it;
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        it.opcode    = tmse_pkg::opcode_e'($urandom_range(0, 1));
        it.pos_one   = $urandom;
        it.pos_two   = $urandom;
        it.vel_one   = $urandom;
        it.vel_two   = $urandom;
        it.force_one = $urandom;
        it.force_two = $urandom;
        queued_items.push_back(it);
        made++;
      end else begin
        queued_items.push_back(random_item(tmse_pkg::OPC_LOAD));
        made++;
        repeat ($urandom_range(1, 30)) begin
          if (made < count) begin
            queued_items.push_back(random_item(tmse_pkg::OPC_STEP));
            made++;
          end
        end
      end
    end
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      step_if.valid        <= 1'b0;
      step_if.opcode       <= tmse_pkg::OPC_LOAD;
      step_if.init_pos_one <= '0;
      step_if.init_pos_two <= '0;
      step_if.init_vel_one <= '0;
      step_if.init_vel_two <= '0;
      step_if.force_one    <= '0;
      step_if.force_two    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (step_if.valid && step_if.ready)
        predicted_states.push_back(euler_advance(offered));
      if (!step_if.valid || step_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          step_if.valid <= 1'b0;
        end else if (queued_items.size() > 0) begin
          offered = queued_items.pop_front();
          step_if.valid        <= 1'b1;
          step_if.opcode       <= offered.opcode;
          step_if.init_pos_one <= offered.pos_one;
          step_if.init_pos_two <= offered.pos_two;
          step_if.init_vel_one <= offered.vel_one;
          step_if.init_vel_two <= offered.vel_two;
          step_if.force_one    <= offered.force_one;
          step_if.force_two    <= offered.force_two;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          step_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string label, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, exp_v, act_v);
      error_count++;
    end
  endtask

  // receiver: checks each item, stalls on changing patterns
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen_results++;
        if (predicted_states.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h %h %h %h", $time,
                   res_if.pos_one, res_if.pos_two, res_if.vel_one, res_if.vel_two);
          error_count++;
        end else begin
          want = predicted_states.pop_front();
          compare_field("pos_one", want.pos_one, res_if.pos_one);
          compare_field("pos_two", want.pos_two, res_if.pos_two);
          compare_field("vel_one", want.vel_one, res_if.vel_one);
          compare_field("vel_two", want.vel_two, res_if.vel_two);
          compare_field("done_res", 32'(want.done_res), 32'(res_if.done_res));
          compare_field("saturated", 32'(want.saturated), 32'(res_if.saturated));
        end
      end
      // long hold-off while the sender still has plenty queued
      if (holds_done < 2 && seen_results >= 300 * (holds_done + 1) &&
          queued_items.size() > 20) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: begin
            wave_cnt++;
            rdy = wave_cnt[2];
          end
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if ((step_if.valid && step_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("two_mass_spring_euler_step_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= tmse_pkg::CFG_TIME_STEP;
    cfg_if.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: step from the reset state, extremes, back-to-back loads
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, tmse_pkg::FX_MAX, tmse_pkg::FX_MIN);
    push_item(tmse_pkg::OPC_LOAD, tmse_pkg::FX_MAX, tmse_pkg::FX_MIN, tmse_pkg::FX_MAX,
              tmse_pkg::FX_MIN, $urandom, $urandom);
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, tmse_pkg::FX_MIN, tmse_pkg::FX_MAX);
    push_item(tmse_pkg::OPC_LOAD, '0, '0, '0, '0, '0, '0);
    push_item(tmse_pkg::OPC_LOAD, tmse_pkg::FX_ONE, -tmse_pkg::FX_ONE, 32'h8000, '0, '0, '0);
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    wait_idle();

    // largest step: second step is refused, spare indexes ignored
    write_all(32'hffff_ffff, tmse_pkg::FX_MAX, tmse_pkg::FX_MIN, tmse_pkg::FX_MAX,
              tmse_pkg::FX_MAX, tmse_pkg::FX_MIN);
    write_register(CFG_SPARE_LO, $urandom);
    write_register(CFG_SPARE_HI, $urandom);
    push_item(tmse_pkg::OPC_LOAD, tmse_pkg::FX_ONE, -tmse_pkg::FX_ONE, tmse_pkg::FX_MAX,
              tmse_pkg::FX_MIN, '0, '0);
    repeat (3) push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, tmse_pkg::FX_MAX,
                         tmse_pkg::FX_MIN);
    wait_idle();

    // zero step never ends
    write_all('0, '0, '0, '0, tmse_pkg::FX_ONE, tmse_pkg::FX_ONE);
    queued_items.push_back(random_item(tmse_pkg::OPC_LOAD));
    repeat (2) push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, tmse_pkg::FX_ONE,
                         -tmse_pkg::FX_ONE);
    wait_idle();

    // running time past end right after load
    write_register(tmse_pkg::CFG_TIME_STEP, 32'h1);
    push_item(tmse_pkg::OPC_LOAD, 32'h1_0000, 32'h2_0000, 32'h8000, -32'h8000, '0, '0);
    repeat (2) push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    wait_idle();

    // three steps run, the fourth is refused, then a reload re-arms
    write_all(tmse_pkg::FX_ONE, 3 * tmse_pkg::FX_ONE, tmse_pkg::FX_ONE, tmse_pkg::FX_ONE,
              tmse_pkg::FX_ONE, tmse_pkg::FX_ONE);
    push_item(tmse_pkg::OPC_LOAD, 32'h4000, -32'h4000, '0, 32'h100, '0, '0);
    repeat (4) push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    push_item(tmse_pkg::OPC_LOAD, 32'h1_0000, '0, '0, '0, '0, '0);
    push_item(tmse_pkg::OPC_STEP, '0, '0, '0, '0, '0, '0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      random_settings();
      queue_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("two_mass_spring_euler_step_test: done, clean");
    else
      $display("two_mass_spring_euler_step_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tmse_pkg.sv
hw/rtl/tmse_if.sv
hw/rtl/two_mass_spring_euler_step.sv
tb/two_mass_spring_euler_step_test.sv
